/* sv/sgv_pkg.sv */
// Shared constants, status codes and the arctangent table of the sphere grid vertex generator.
`timescale 1ns / 1ps
package sgv_pkg;

    localparam int COUNT_BITS_DEF    = 10;
    localparam int CORDIC_STAGES_DEF = 16;

    // Quotient width of the grid step divider; the angle span fits in it.
    localparam int QUO_W     = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    // Grid angle in 1/256 degree, start plus step.
    localparam int ANG_W     = 18;
    // CORDIC datapath: x and y in Q2.30, z in degrees Q.16.
    localparam int XY_W      = 32;
    localparam int Z_W       = 30;
    localparam int POS_W     = 17;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LON_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LON_END    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_END    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LON_COUNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_COUNT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [16:0] LAT_MAX = 17'd46080;
    localparam logic [16:0] LON_MAX = 17'd92160;

    // Half, quarter and full turn in 1/256 degree.
    localparam int ANG_HALF    = 46080;
    localparam int ANG_QUARTER = 23040;
    localparam int ANG_FULL    = 92160;

    localparam logic signed [XY_W-1:0] CORDIC_K = 32'sd652032875;
    localparam logic signed [POS_W-1:0] POS_LIMIT = 17'sd65535;

    // round(atan(2^-i) in degrees * 2^16)
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 30'sd2949120;
            1:  v = 30'sd1740967;
            2:  v = 30'sd919879;
            3:  v = 30'sd466945;
            4:  v = 30'sd234379;
            5:  v = 30'sd117304;
            6:  v = 30'sd58666;
            7:  v = 30'sd29335;
            8:  v = 30'sd14668;
            9:  v = 30'sd7334;
            10: v = 30'sd3667;
            11: v = 30'sd1833;
            12: v = 30'sd917;
            13: v = 30'sd458;
            14: v = 30'sd229;
            15: v = 30'sd115;
            16: v = 30'sd57;
            17: v = 30'sd29;
            18: v = 30'sd14;
            19: v = 30'sd7;
            20: v = 30'sd4;
            21: v = 30'sd2;
            22: v = 30'sd1;
            default: v = 30'sd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/sgv_div.sv */
// Pipelined restoring divider giving one quotient bit per stage.
`timescale 1ns / 1ps
module sgv_div #(
    parameter int CB     = sgv_pkg::COUNT_BITS_DEF,
    parameter int SIDE_W = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [CB+sgv_pkg::QUO_W-1:0]      i_num,
    input  logic [CB-1:0]                     i_den,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic [sgv_pkg::QUO_W-1:0]         o_quo,
    output logic [SIDE_W-1:0]                 o_side
);
    import sgv_pkg::*;

    localparam int NW = CB + QUO_W;

    logic [CB-1:0]     w_rem  [0:QUO_W];
    logic [QUO_W-1:0]  w_low  [0:QUO_W];
    logic [QUO_W-1:0]  w_q    [0:QUO_W];
    logic              w_v    [0:QUO_W];
    logic [SIDE_W-1:0] w_side [0:QUO_W];

    // The upper part of the numerator is below the divisor for any item in the grid.
    assign w_rem[0]  = i_num[NW-1:QUO_W];
    assign w_low[0]  = i_num[QUO_W-1:0];
    assign w_q[0]    = '0;
    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [CB:0]       w_t;
        logic [CB:0]       w_sub;
        logic              w_ge;
        logic [CB-1:0]     r_rem;
        logic [QUO_W-1:0]  r_low;
        logic [QUO_W-1:0]  r_q;
        logic              r_v;
        logic [SIDE_W-1:0] r_side;

        assign w_t   = {w_rem[k], w_low[k][QUO_W-1]};
        assign w_ge  = (w_t >= {1'b0, i_den});
        assign w_sub = w_t - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= w_ge ? w_sub[CB-1:0] : w_t[CB-1:0];
            r_low  <= {w_low[k][QUO_W-2:0], 1'b0};
            r_q    <= {w_q[k][QUO_W-2:0], w_ge};
            r_side <= w_side[k];
        end

        assign w_rem[k+1]  = r_rem;
        assign w_low[k+1]  = r_low;
        assign w_q[k+1]    = r_q;
        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[QUO_W];
    assign o_quo   = w_q[QUO_W];
    assign o_side  = w_side[QUO_W];

endmodule

/* sv/sgv_cordic.sv */
// Pipelined rotation CORDIC giving cosine and sine of a grid angle.
`timescale 1ns / 1ps
module sgv_cordic #(
    parameter int STAGES = sgv_pkg::CORDIC_STAGES_DEF,
    parameter int SIDE_W = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [sgv_pkg::ANG_W-1:0]          i_ang,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic signed [sgv_pkg::XY_W-1:0]    o_cos,
    output logic signed [sgv_pkg::XY_W-1:0]    o_sin,
    output logic [SIDE_W-1:0]                  o_side
);
    import sgv_pkg::*;

    localparam int AW = ANG_W + 2;
    localparam logic signed [AW-1:0] S_HALF    = AW'(ANG_HALF);
    localparam logic signed [AW-1:0] S_QUARTER = AW'(ANG_QUARTER);
    localparam logic signed [AW-1:0] S_FULL    = AW'(ANG_FULL);

    logic signed [XY_W-1:0] r_x    [0:STAGES];
    logic signed [XY_W-1:0] r_y    [0:STAGES];
    logic signed [Z_W-1:0]  r_z    [0:STAGES];
    logic                   r_neg  [0:STAGES];
    logic                   r_v    [0:STAGES];
    logic [SIDE_W-1:0]      r_side [0:STAGES];

    logic signed [AW-1:0] w_s0;
    logic signed [AW-1:0] w_s1;
    logic                 w_neg;

    // Fold the angle into [-90, 90] degrees; a half-turn fold negates both outputs.
    always_comb begin
        w_s0 = $signed({2'b00, i_ang});
        if (w_s0 >= S_HALF) begin
            w_s0 = w_s0 - S_FULL;
        end
        w_s1  = w_s0;
        w_neg = 1'b0;
        if (w_s0 > S_QUARTER) begin
            w_s1  = w_s0 - S_HALF;
            w_neg = 1'b1;
        end else if (w_s0 < -S_QUARTER) begin
            w_s1  = w_s0 + S_HALF;
            w_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= CORDIC_K;
        r_y[0]    <= '0;
        r_z[0]    <= $signed({{(Z_W-AW-8){w_s1[AW-1]}}, w_s1, 8'b0});
        r_neg[0]  <= w_neg;
        r_side[0] <= i_side;
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [XY_W-1:0] w_dx;
        logic signed [XY_W-1:0] w_dy;

        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        // A zero residual rotates in the positive direction.
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - w_dx;
                r_y[i+1] <= r_y[i] + w_dy;
                r_z[i+1] <= r_z[i] - atan_q16(i);
            end else begin
                r_x[i+1] <= r_x[i] + w_dx;
                r_y[i+1] <= r_y[i] - w_dy;
                r_z[i+1] <= r_z[i] + atan_q16(i);
            end
            r_neg[i+1]  <= r_neg[i];
            r_side[i+1] <= r_side[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        o_cos  <= r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];
        o_sin  <= r_neg[STAGES] ? -r_y[STAGES] : r_y[STAGES];
        o_side <= r_side[STAGES];
    end

endmodule

/* sv/sgv_scale.sv */
// Product, radius scaling, rounding and saturation pipeline for the vertex coordinates.
`timescale 1ns / 1ps
module sgv_scale #(
    parameter int SLOT_W = 2 * sgv_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [sgv_pkg::XY_W-1:0]    i_sp,
    input  logic signed [sgv_pkg::XY_W-1:0]    i_cp,
    input  logic signed [sgv_pkg::XY_W-1:0]    i_ca,
    input  logic signed [sgv_pkg::XY_W-1:0]    i_sa,
    input  logic [15:0]                        i_radius,
    input  logic [1:0]                         i_status,
    input  logic [SLOT_W-1:0]                  i_slot,
    output logic                               o_valid,
    output logic signed [sgv_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [sgv_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [sgv_pkg::POS_W-1:0]   o_pos_z,
    output logic [SLOT_W-1:0]                  o_slot,
    output logic [1:0]                         o_status
);
    import sgv_pkg::*;

    localparam int MW = 2 * XY_W;
    localparam int TW = XY_W + 1;
    localparam int PW = TW + 17;
    localparam logic signed [MW-1:0] HALF_M = MW'(64'sd536870912);
    localparam logic signed [PW-1:0] HALF_P = PW'(64'sd536870912);

    function automatic logic signed [POS_W-1:0] sat_round(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = (v + HALF_P) >>> 30;
        if (t > PW'(POS_LIMIT)) begin
            return POS_LIMIT;
        end else if (t < -PW'(POS_LIMIT)) begin
            return -POS_LIMIT;
        end
        return t[POS_W-1:0];
    endfunction

    logic signed [16:0]     w_rad;
    logic signed [MW-1:0]   w_rx;
    logic signed [MW-1:0]   w_ry;

    logic [3:0]             r_v;
    logic [1:0]             r_st   [0:2];
    logic [SLOT_W-1:0]      r_slot [0:2];
    logic signed [MW-1:0]   r1_px;
    logic signed [MW-1:0]   r1_py;
    logic signed [XY_W-1:0] r1_cp;
    logic signed [TW-1:0]   r2_tx;
    logic signed [TW-1:0]   r2_ty;
    logic signed [PW-1:0]   r2_pz;
    logic signed [PW-1:0]   r3_px;
    logic signed [PW-1:0]   r3_py;
    logic signed [PW-1:0]   r3_pz;

    assign w_rad = $signed({1'b0, i_radius});
    assign w_rx  = (r1_px + HALF_M) >>> 30;
    assign w_ry  = (r1_py + HALF_M) >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px     <= i_sp * i_ca;
        r1_py     <= i_sp * i_sa;
        r1_cp     <= i_cp;
        r_st[0]   <= i_status;
        r_slot[0] <= i_slot;

        r2_tx     <= w_rx[TW-1:0];
        r2_ty     <= w_ry[TW-1:0];
        r2_pz     <= w_rad * r1_cp;
        r_st[1]   <= r_st[0];
        r_slot[1] <= r_slot[0];

        r3_px     <= w_rad * r2_tx;
        r3_py     <= w_rad * r2_ty;
        r3_pz     <= r2_pz;
        r_st[2]   <= r_st[1];
        r_slot[2] <= r_slot[1];

        // Error results carry only their status.
        if (r_st[2] != ST_OK) begin
            o_pos_x <= '0;
            o_pos_y <= '0;
            o_pos_z <= '0;
            o_slot  <= '0;
        end else begin
            o_pos_x <= sat_round(r3_px);
            o_pos_y <= sat_round(r3_py);
            o_pos_z <= sat_round(r3_pz);
            o_slot  <= r_slot[2];
        end
        o_status <= r_st[2];
    end

    assign o_valid = r_v[3];

endmodule

/* sv/sphere_grid_vertex_generator.sv */
// Top level of the sphere grid vertex generator: registers, grid setup and the pipeline.
`timescale 1ns / 1ps
//  Channel   | Handshake           | Payload
//  ----------+---------------------+-----------------------------------------------
//  input     | start, busy         | i_lat_index, i_lon_index
//  result    | o_done (one cycle)  | o_pos_x, o_pos_y, o_pos_z, o_slot, o_status
//  config    | i_cfg_we            | i_cfg_idx, i_cfg_data
//
//  One beat is taken every cycle; busy is always low.
//  Each result passes the entry register, the 17-stage
//  grid step divider, the CORDIC stages and the scaling multipliers.
//  Reset clears the valid bits of every stage and loads the register defaults.
//  Results cannot be held off, so nothing in the pipeline ever stalls.
module sphere_grid_vertex_generator #(
    parameter int COUNT_BITS    = sgv_pkg::COUNT_BITS_DEF,
    parameter int CORDIC_STAGES = sgv_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [COUNT_BITS-1:0]              i_lat_index,
    input  logic [COUNT_BITS-1:0]              i_lon_index,
    output logic                               o_done,
    output logic signed [sgv_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [sgv_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [sgv_pkg::POS_W-1:0]   o_pos_z,
    output logic [2*COUNT_BITS-1:0]            o_slot,
    output logic [1:0]                         o_status,
    input  logic                               i_cfg_we,
    input  logic [sgv_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sgv_pkg::CFG_W-1:0]          i_cfg_data
);
    import sgv_pkg::*;

    localparam int CB      = COUNT_BITS;
    localparam int NW      = CB + QUO_W;
    localparam int SLW     = 2 * CB;
    localparam int LATENCY = QUO_W + CORDIC_STAGES + 7;

    // Configuration registers.
    logic [15:0]   r_radius;
    logic [16:0]   r_lon_start;
    logic [16:0]   r_lon_end;
    logic [15:0]   r_lat_start;
    logic [15:0]   r_lat_end;
    logic [CB-1:0] r_lon_count;
    logic [CB-1:0] r_lat_count;
    logic          r_order_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= 16'd256;
            r_lon_start  <= 17'd0;
            r_lon_end    <= 17'd92160;
            r_lat_start  <= 16'd0;
            r_lat_end    <= 16'd46080;
            r_lon_count  <= CB'(360);
            r_lat_count  <= CB'(180);
            r_order_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS:     r_radius     <= i_cfg_data[15:0];
                REG_LON_START:  r_lon_start  <= i_cfg_data;
                REG_LON_END:    r_lon_end    <= i_cfg_data;
                REG_LAT_START:  r_lat_start  <= i_cfg_data[15:0];
                REG_LAT_END:    r_lat_end    <= i_cfg_data[15:0];
                REG_LON_COUNT:  r_lon_count  <= i_cfg_data[CB-1:0];
                REG_LAT_COUNT:  r_lat_count  <= i_cfg_data[CB-1:0];
                REG_ORDER_MODE: r_order_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamped grid setup. The user must change registers only while the pipeline is empty
    // (the block itself does not enforce this), so every stage reads these directly.
    logic [16:0]   w_las;
    logic [16:0]   w_lae;
    logic [16:0]   w_los;
    logic [16:0]   w_loe;
    logic [CB-1:0] w_lac;
    logic [CB-1:0] w_loc;

    assign w_las = ({1'b0, r_lat_start} > LAT_MAX) ? LAT_MAX : {1'b0, r_lat_start};
    assign w_lae = ({1'b0, r_lat_end} > LAT_MAX) ? LAT_MAX : {1'b0, r_lat_end};
    assign w_los = (r_lon_start > LON_MAX) ? LON_MAX : r_lon_start;
    assign w_loe = (r_lon_end > LON_MAX) ? LON_MAX : r_lon_end;
    assign w_lac = (r_lat_count < CB'(2)) ? CB'(2) : r_lat_count;
    assign w_loc = (r_lon_count < CB'(2)) ? CB'(2) : r_lon_count;

    // Entry stage: status, divider numerators with the half-count rounding term, and slot.
    logic [1:0]     w_status;
    logic [NW-1:0]  w_num_lat;
    logic [NW-1:0]  w_num_lon;
    logic [CB-1:0]  w_sa;
    logic [CB-1:0]  w_sb;
    logic [CB-1:0]  w_sc;
    logic [SLW-1:0] w_slot;

    always_comb begin
        if (w_las >= w_lae || w_los >= w_loe) begin
            w_status = ST_EMPTY;
        end else if (i_lat_index > w_lac || i_lon_index > w_loc) begin
            w_status = ST_RANGE;
        end else begin
            w_status = ST_OK;
        end
    end

    assign w_num_lat = NW'(i_lat_index) * NW'(w_lae - w_las) + NW'(w_lac >> 1);
    assign w_num_lon = NW'(i_lon_index) * NW'(w_loe - w_los) + NW'(w_loc >> 1);

    // Row-major slot: the outer index times the inner row length, plus the inner index.
    assign w_sa   = r_order_mode ? i_lon_index : i_lat_index;
    assign w_sb   = r_order_mode ? w_lac : w_loc;
    assign w_sc   = r_order_mode ? i_lat_index : i_lon_index;
    assign w_slot = SLW'(w_sa) * (SLW'(w_sb) + SLW'(1)) + SLW'(w_sc);

    logic           r_s0_valid;
    logic [NW-1:0]  r_s0_num_lat;
    logic [NW-1:0]  r_s0_num_lon;
    logic [1:0]     r_s0_status;
    logic [SLW-1:0] r_s0_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_num_lat <= w_num_lat;
        r_s0_num_lon <= w_num_lon;
        r_s0_status  <= w_status;
        r_s0_slot    <= w_slot;
    end

    assign busy = 1'b0;

    // Grid steps: the status rides with the polar chain, the slot with the azimuth chain.
    logic             w_dv_lat;
    logic             w_dv_lon;
    logic [QUO_W-1:0] w_q_lat;
    logic [QUO_W-1:0] w_q_lon;
    logic [1:0]       w_d_status;
    logic [SLW-1:0]   w_d_slot;

    sgv_div #(.CB(CB), .SIDE_W(2)) u_div_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .i_num   (r_s0_num_lat),
        .i_den   (w_lac),
        .i_side  (r_s0_status),
        .o_valid (w_dv_lat),
        .o_quo   (w_q_lat),
        .o_side  (w_d_status)
    );

    sgv_div #(.CB(CB), .SIDE_W(SLW)) u_div_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .i_num   (r_s0_num_lon),
        .i_den   (w_loc),
        .i_side  (r_s0_slot),
        .o_valid (w_dv_lon),
        .o_quo   (w_q_lon),
        .o_side  (w_d_slot)
    );

    logic [ANG_W-1:0] w_ang_lat;
    logic [ANG_W-1:0] w_ang_lon;

    assign w_ang_lat = ANG_W'(w_q_lat) + ANG_W'(w_las);
    assign w_ang_lon = ANG_W'(w_q_lon) + ANG_W'(w_los);

    logic                   w_cv_lat;
    logic                   w_cv_lon;
    logic signed [XY_W-1:0] w_cp;
    logic signed [XY_W-1:0] w_sp;
    logic signed [XY_W-1:0] w_ca;
    logic signed [XY_W-1:0] w_sa_trig;
    logic [1:0]             w_c_status;
    logic [SLW-1:0]         w_c_slot;

    sgv_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(2)) u_cordic_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv_lat),
        .i_ang   (w_ang_lat),
        .i_side  (w_d_status),
        .o_valid (w_cv_lat),
        .o_cos   (w_cp),
        .o_sin   (w_sp),
        .o_side  (w_c_status)
    );

    sgv_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SLW)) u_cordic_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv_lon),
        .i_ang   (w_ang_lon),
        .i_side  (w_d_slot),
        .o_valid (w_cv_lon),
        .o_cos   (w_ca),
        .o_sin   (w_sa_trig),
        .o_side  (w_c_slot)
    );

    sgv_scale #(.SLOT_W(SLW)) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_cv_lat),
        .i_sp     (w_sp),
        .i_cp     (w_cp),
        .i_ca     (w_ca),
        .i_sa     (w_sa_trig),
        .i_radius (r_radius),
        .i_status (w_c_status),
        .i_slot   (w_c_slot),
        .o_valid  (o_done),
        .o_pos_x  (o_pos_x),
        .o_pos_y  (o_pos_y),
        .o_pos_z  (o_pos_z),
        .o_slot   (o_slot),
        .o_status (o_status)
    );

    // The two angle chains must stay in lockstep.
    a_div_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_lat == w_dv_lon)
        else $error("divider chains out of step");

    a_cordic_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cv_lat == w_cv_lon)
        else $error("CORDIC chains out of step");

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result without a matching input beat");

    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |->
            (o_pos_x == 0 && o_pos_y == 0 && o_pos_z == 0 && o_slot == 0))
        else $error("error result carries data");

endmodule
